/* design/rcfad_pkg.sv */
// Shared constants, codes and helpers for the remote-control fragment assembler/decoder.
package rcfad_pkg;

    localparam int ID_W        = 11;
    localparam int TICK_W      = 16;
    localparam int WORD_W      = 64;
    localparam int CH_W        = 11;
    localparam int AXIS_W      = 16;
    localparam int SW_W        = 4;
    localparam int BTN_W       = 2;
    localparam int KIND_W      = 2;
    localparam int REQ_W       = 1;

    localparam int S_TDATA_W   = 80;
    localparam int M_TDATA_W   = 128;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;

    localparam logic [ID_W-1:0]   FIRST_ID_RST   = 11'd209;
    localparam logic [ID_W-1:0]   SECOND_ID_RST  = 11'd210;
    localparam logic [ID_W-1:0]   THIRD_ID_RST   = 11'd211;
    localparam logic [TICK_W-1:0] TIMEOUT_RST    = 16'd100;

    localparam logic [1:0] REG_FIRST_ID  = 2'd0;
    localparam logic [1:0] REG_SECOND_ID = 2'd1;
    localparam logic [1:0] REG_THIRD_ID  = 2'd2;
    localparam logic [1:0] REG_TIMEOUT   = 2'd3;

    localparam logic [KIND_W-1:0] KIND_VALID   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REJECT  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TIMEOUT = 2'd2;

    localparam logic [REQ_W-1:0]  REQ_FRAME = 1'b0;
    localparam logic [REQ_W-1:0]  REQ_TICK  = 1'b1;

    localparam logic [1:0] MASK_NONE  = 2'b00;
    localparam logic [1:0] MASK_FIRST = 2'b01;
    localparam logic [1:0] MASK_BOTH  = 2'b11;

    localparam logic [SW_W-1:0] SW_SAFE = 4'hF;

    localparam logic signed [CH_W:0] CH_OFFSET = 12'sd1024;
    localparam logic signed [CH_W:0] CH_LIMIT  = 12'sd660;

    // raw 11-bit channel to offset value, one bit wider for the range check
    function automatic logic signed [CH_W:0] chan_of(input logic [CH_W-1:0] raw);
        chan_of = $signed({1'b0, raw}) - CH_OFFSET;
    endfunction

    function automatic logic chan_bad(input logic signed [CH_W:0] c);
        chan_bad = (c < -CH_LIMIT) || (c > CH_LIMIT);
    endfunction

endpackage

/* design/rc_fragment_assembler_decoder_core.sv */
// Top level: fragment assembly, frame decode, link timeout and APB registers.
// Throughput: one request per cycle while m_axis_tready holds; requests pass an input
// register, then the decode and state update, then the result register.
// Reset (aresetn low, synchronous): registers to defaults, fragment mask and link
// state cleared, both stages empty; assembly words stay undefined until written.
module rc_fragment_assembler_decoder_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    // s_axis_tdata: frame_id[10:0], frame_ok[11], payload[75:12], zero pad
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [rcfad_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // s_axis_tuser: req_type[0]
    input  logic [rcfad_pkg::REQ_W-1:0]       s_axis_tuser,
    // m_axis_tdata: stick_ch0..3, wheel_ch4 (11 b each), switch_pair (4),
    // mouse_dx, mouse_dy, mouse_dz (16 each), mouse_buttons (2), key_bits (16), zero pad
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [rcfad_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // m_axis_tuser: result_kind[1:0]
    output logic [rcfad_pkg::KIND_W-1:0]      m_axis_tuser,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rcfad_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [rcfad_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [rcfad_pkg::APB_DATA_W-1:0]  prdata,
    output logic                              pready
);
    import rcfad_pkg::*;

    // configuration
    logic [ID_W-1:0]   first_id_reg, second_id_reg, third_id_reg;
    logic [TICK_W-1:0] timeout_reg;
    logic              cfg_wr;
    logic [1:0]        cfg_idx;

    // input stage
    logic              in_valid_reg;
    logic [REQ_W-1:0]  in_req_reg;
    logic [ID_W-1:0]   in_id_reg;
    logic              in_ok_reg;
    logic [WORD_W-1:0] in_data_reg;

    // block state
    logic [WORD_W-1:0] asm0_reg, asm1_reg;
    logic [1:0]        mask_reg, mask_next;
    logic              online_reg, online_next;
    logic [TICK_W-1:0] ticks_reg, ticks_next, ticks_inc;
    logic              store0, store1;

    // result stage
    logic                 out_valid_reg;
    logic [KIND_W-1:0]    out_kind_reg;
    logic [M_TDATA_W-1:0] out_data_reg;

    logic                 adv;
    logic                 res_valid;
    logic [KIND_W-1:0]    res_kind;
    logic [M_TDATA_W-1:0] res_data;
    logic [M_TDATA_W-1:0] safe_data;
    logic [M_TDATA_W-1:0] good_data;

    logic signed [CH_W:0] ch0, ch1, ch2, ch3, ch4;
    logic [CH_W-1:0]      ch4_out;
    logic [1:0]           sw0, sw1;
    logic                 frame_bad;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[APB_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_id_reg  <= FIRST_ID_RST;
            second_id_reg <= SECOND_ID_RST;
            third_id_reg  <= THIRD_ID_RST;
            timeout_reg   <= TIMEOUT_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_FIRST_ID:  first_id_reg  <= pwdata[ID_W-1:0];
                REG_SECOND_ID: second_id_reg <= pwdata[ID_W-1:0];
                REG_THIRD_ID:  third_id_reg  <= pwdata[ID_W-1:0];
                REG_TIMEOUT:   timeout_reg   <= pwdata[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_FIRST_ID:  prdata = {{(APB_DATA_W-ID_W){1'b0}}, first_id_reg};
            REG_SECOND_ID: prdata = {{(APB_DATA_W-ID_W){1'b0}}, second_id_reg};
            REG_THIRD_ID:  prdata = {{(APB_DATA_W-ID_W){1'b0}}, third_id_reg};
            REG_TIMEOUT:   prdata = {{(APB_DATA_W-TICK_W){1'b0}}, timeout_reg};
            default:       prdata = '0;
        endcase
    end

    // pipeline control
    assign adv           = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_req_reg  <= s_axis_tuser;
            in_id_reg   <= s_axis_tdata[ID_W-1:0];
            in_ok_reg   <= s_axis_tdata[ID_W];
            in_data_reg <= s_axis_tdata[ID_W+WORD_W:ID_W+1];
        end
    end

    // frame decode from the held words and the third fragment
    assign ch0 = chan_of(asm0_reg[10:0]);
    assign ch1 = chan_of(asm0_reg[21:11]);
    assign ch2 = chan_of(asm0_reg[32:22]);
    assign ch3 = chan_of(asm0_reg[43:33]);
    assign ch4 = chan_of(in_data_reg[10:0]);
    assign sw0 = asm0_reg[47:46];
    assign sw1 = asm0_reg[45:44];

    assign frame_bad = chan_bad(ch0) || chan_bad(ch1) || chan_bad(ch2) || chan_bad(ch3)
                    || (sw0 == 2'd0) || (sw1 == 2'd0);
    assign ch4_out   = chan_bad(ch4) ? '0 : ch4[CH_W-1:0];

    assign safe_data = {{(M_TDATA_W-SW_W-5*CH_W){1'b0}}, SW_SAFE, {(5*CH_W){1'b0}}};
    assign good_data = {3'b000,
                        asm1_reg[63:48],
                        asm1_reg[40], asm1_reg[32],
                        asm1_reg[31:16],
                        asm1_reg[15:0],
                        asm0_reg[63:48],
                        sw0, sw1,
                        ch4_out,
                        ch3[CH_W-1:0], ch2[CH_W-1:0], ch1[CH_W-1:0], ch0[CH_W-1:0]};

    assign ticks_inc = (ticks_reg == {TICK_W{1'b1}}) ? ticks_reg : ticks_reg + 16'd1;

    always_comb begin
        res_valid   = 1'b0;
        res_kind    = KIND_VALID;
        res_data    = good_data;
        mask_next   = mask_reg;
        online_next = online_reg;
        ticks_next  = ticks_reg;
        store0      = 1'b0;
        store1      = 1'b0;
        if (in_req_reg == REQ_TICK) begin
            if (online_reg) begin
                ticks_next = ticks_inc;
                if (ticks_inc >= timeout_reg) begin
                    online_next = 1'b0;
                    res_valid   = 1'b1;
                    res_kind    = KIND_TIMEOUT;
                    res_data    = safe_data;
                end
            end
        end else if (in_ok_reg) begin
            if (in_id_reg == first_id_reg) begin
                store0    = 1'b1;
                mask_next = MASK_FIRST;
            end else if (in_id_reg == second_id_reg) begin
                if (mask_reg != MASK_FIRST) begin
                    mask_next = MASK_NONE;
                end else begin
                    store1    = 1'b1;
                    mask_next = MASK_BOTH;
                end
            end else if (in_id_reg == third_id_reg) begin
                mask_next = MASK_NONE;
                if (mask_reg == MASK_BOTH && in_data_reg[63:16] == '0) begin
                    res_valid = 1'b1;
                    if (frame_bad) begin
                        res_kind = KIND_REJECT;
                        res_data = safe_data;
                    end else begin
                        online_next = 1'b1;
                        ticks_next  = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg   <= MASK_NONE;
            online_reg <= 1'b0;
            ticks_reg  <= '0;
        end else if (adv) begin
            mask_reg   <= mask_next;
            online_reg <= online_next;
            ticks_reg  <= ticks_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && store0) begin
            asm0_reg <= in_data_reg;
        end
        if (adv && store1) begin
            asm1_reg <= in_data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_axis_tready) begin
            out_valid_reg <= adv && res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && res_valid) begin
            out_kind_reg <= res_kind;
            out_data_reg <= res_data;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tdata  = out_data_reg;

    a_mask_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        mask_reg != 2'b10)
        else $error("fragment mask holds second without first");

    a_timeout_drops_link: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && res_valid && res_kind == KIND_TIMEOUT) |=> !online_reg)
        else $error("timeout result left link online");

    a_valid_sets_link: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && res_valid && res_kind == KIND_VALID) |=> (online_reg && ticks_reg == '0))
        else $error("valid frame did not restart link");

    a_safe_switches: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_kind_reg != KIND_VALID) |-> (out_data_reg[58:55] == SW_SAFE))
        else $error("safe result without safe switches");

endmodule
